// ----- sv/dtw_pkg.sv -----
// Shared types and constants for the DTW cost and path block.
`timescale 1ns / 1ps
`default_nettype none
package dtw_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int PATH_CAP = MAX_ROWS + MAX_COLS - 1;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIST_W   = 16;
  localparam int COST_W   = 24;
  localparam int LEN_W    = 7;
  localparam int SIZE_W   = 7;
  localparam int CIDX_W   = 8;

  localparam logic [COST_W-1:0] COST_ONES = {COST_W{1'b1}};

  localparam logic [CIDX_W-1:0] REG_ROWS = 8'd0;
  localparam logic [CIDX_W-1:0] REG_COLS = 8'd1;

  localparam logic [1:0] DIR_LEFT = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DIAG = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BT_READ,
    ST_BT_STEP,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              action;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  path_index;
  } item_t;

  typedef struct packed {
    logic              index_valid;
    logic [COL_W-1:0]  path_col;
    logic [ROW_W-1:0]  path_row;
    logic [LEN_W-1:0]  path_length;
    logic [COST_W-1:0] total_cost;
  } result_t;

  typedef struct packed {
    logic              restart;
    logic [SIZE_W-1:0] nr;
    logic [SIZE_W-1:0] nc;
  } cfg_t;

endpackage
`default_nettype wire

// ----- sv/dtw_front.sv -----
// Input side: accepts requests into a two-entry queue ahead of the core.
`timescale 1ns / 1ps
`default_nettype none
module dtw_front
  import dtw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       q_valid,
  input  wire logic  q_ready,
  output item_t      q_item
);

  item_t      slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- sv/dtw_back.sv -----
// Core: accumulates costs cell by cell, backtracks the path and serves path reads.
`timescale 1ns / 1ps
`default_nettype none
module dtw_back
  import dtw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire item_t q_item,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  state_t state;
  state_t state_next;

  logic [COST_W-1:0] rowbuf [MAX_COLS];
  logic [1:0]        dirmem [MAX_ROWS*MAX_COLS];
  logic [ROW_W+COL_W-1:0] pathmem [PATH_CAP];

  logic [COL_W-1:0]       rb_addr;
  logic [COST_W-1:0]      rb_q;
  logic [ROW_W+COL_W-1:0] dir_raddr;
  logic [1:0]             dir_q;
  logic [LEN_W-1:0]       pm_addr;
  logic [ROW_W+COL_W-1:0] pm_q;

  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;
  logic [DIST_W-1:0] ld_dist;
  logic [COST_W-1:0] left_cost;
  logic [COST_W-1:0] diag_cost;
  logic [COST_W-1:0] total;
  logic [LEN_W-1:0]  len;
  logic [ROW_W-1:0]  bt_i;
  logic [COL_W-1:0]  bt_j;
  logic [LEN_W-1:0]  bt_n;
  logic              rd_ok;

  logic [ROW_W-1:0]  r_eff;
  logic [COL_W-1:0]  c_eff;
  logic              have;
  logic [COST_W-1:0] best;
  logic [1:0]        dir;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cost;
  logic              last_col;
  logic              last_row;
  logic              idx_ok;
  logic [LEN_W-1:0]  n_next;
  logic              bt_done;

  // Wrap a stale position back to the origin.
  always_comb begin
    if ({1'b0, row_pos} >= cfg.nr || {1'b0, col_pos} >= cfg.nc) begin
      r_eff = '0;
      c_eff = '0;
    end else begin
      r_eff = row_pos;
      c_eff = col_pos;
    end
  end

  assign rb_addr   = c_eff;
  assign dir_raddr = {bt_i, bt_j};
  assign idx_ok    = q_item.path_index < len;
  assign pm_addr   = idx_ok ? (len - LEN_W'(1) - q_item.path_index) : '0;
  assign last_col  = ({1'b0, col_pos} == cfg.nc - SIZE_W'(1));
  assign last_row  = ({1'b0, row_pos} == cfg.nr - SIZE_W'(1));
  assign n_next    = bt_n + LEN_W'(1);

  // Pick the least of left, up and diagonal; first wins on ties.
  always_comb begin
    have = 1'b0;
    best = '0;
    dir  = DIR_DIAG;
    if (col_pos != '0) begin
      best = left_cost;
      dir  = DIR_LEFT;
      have = 1'b1;
    end
    if (row_pos != '0 && (!have || rb_q < best)) begin
      best = rb_q;
      dir  = DIR_UP;
      have = 1'b1;
    end
    if (row_pos != '0 && col_pos != '0) begin
      if (!have || diag_cost < best) begin
        best = diag_cost;
        dir  = DIR_DIAG;
      end
    end else if (row_pos == '0 && col_pos == '0) begin
      best = '0;
      dir  = DIR_DIAG;
    end
    sum  = {1'b0, best} + {{(COST_W+1-DIST_W){1'b0}}, ld_dist};
    cost = sum[COST_W] ? COST_ONES : sum[COST_W-1:0];
  end

  always_comb begin
    unique case (dir_q)
      DIR_LEFT: bt_done = (bt_j == '0);
      DIR_UP:   bt_done = (bt_i == '0);
      default:  bt_done = (bt_i == '0) || (bt_j == '0);
    endcase
    if (bt_i == '0 && bt_j == '0) bt_done = 1'b1;
  end

  // Memories.
  always_ff @(posedge clk) begin
    rb_q  <= rowbuf[rb_addr];
    dir_q <= dirmem[dir_raddr];
    pm_q  <= pathmem[pm_addr];
    if (state == ST_LOAD) begin
      rowbuf[col_pos]           <= cost;
      dirmem[{row_pos, col_pos}] <= dir;
    end
    if (state == ST_BT_STEP) begin
      pathmem[bt_n] <= {bt_i, bt_j};
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = q_item.action ? ST_READ : ST_LOAD;
      end
      ST_LOAD: begin
        if (last_col && last_row) state_next = ST_BT_READ;
        else state_next = ST_IDLE;
      end
      ST_BT_READ: state_next = ST_BT_STEP;
      ST_BT_STEP: state_next = bt_done ? ST_EMIT : ST_BT_READ;
      ST_READ:    state_next = ST_EMIT;
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      total   <= '0;
      len     <= '0;
    end else if (cfg.restart) begin
      row_pos <= '0;
      col_pos <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid && !q_item.action) begin
            row_pos <= r_eff;
            col_pos <= c_eff;
          end
        end
        ST_LOAD: begin
          if (last_col) begin
            col_pos <= '0;
            if (last_row) begin
              row_pos <= '0;
              total   <= cost;
            end else begin
              row_pos <= row_pos + ROW_W'(1);
            end
          end else begin
            col_pos <= col_pos + COL_W'(1);
          end
        end
        ST_BT_STEP: begin
          if (bt_done) len <= n_next;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        ld_dist <= q_item.distance;
        rd_ok   <= idx_ok;
        bt_n    <= '0;
      end
      ST_LOAD: begin
        left_cost <= cost;
        diag_cost <= rb_q;
        bt_i      <= row_pos;
        bt_j      <= col_pos;
        res       <= '{index_valid: 1'b0, path_col: '0, path_row: '0,
                       path_length: len, total_cost: cost};
      end
      ST_BT_STEP: begin
        bt_n <= n_next;
        res.path_length <= n_next;
        if (!bt_done) begin
          unique case (dir_q)
            DIR_LEFT: bt_j <= bt_j - COL_W'(1);
            DIR_UP:   bt_i <= bt_i - ROW_W'(1);
            default: begin
              bt_i <= bt_i - ROW_W'(1);
              bt_j <= bt_j - COL_W'(1);
            end
          endcase
        end
      end
      ST_READ: begin
        res <= '{index_valid: rd_ok,
                 path_col: rd_ok ? pm_q[COL_W-1:0] : '0,
                 path_row: rd_ok ? pm_q[ROW_W+COL_W-1:COL_W] : '0,
                 path_length: len, total_cost: total};
      end
      default: ;
    endcase
  end

  a_bt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_BT_STEP |-> bt_n < LEN_W'(PATH_CAP))
    else $error("backtrack ran past path capacity");

  a_last_cell_bt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && last_col && last_row && !cfg.restart) |=> state == ST_BT_READ)
    else $error("last cell did not start backtrack");

  a_valid_idx_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.index_valid) |-> res.path_length != '0)
    else $error("valid path step with empty path");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ({1'b0, row_pos} < cfg.nr && {1'b0, col_pos} < cfg.nc))
    else $error("cell position outside matrix");

endmodule
`default_nettype wire

// ----- sv/dtw_cost_and_path.sv -----
// Top level of the DTW cost and path block.
`timescale 1ns / 1ps
`default_nettype none
// Dynamic time warping over the full window with path backtrack. Load requests (tuser 0)
// stream the distance matrix in row-major order, rows_in_use x cols_in_use (up to 64 x 64);
// the core handles each as a row buffer read, then add and compare. The last load
// triggers a backtrack in which each path step is a direction memory read, then the step, up
// to 127 steps, and then returns total cost and path length. Read requests (tuser 1) go
// through path memory read, result build and handoff, and return one path step. A two-entry
// input queue keeps taking requests while the core works. A write to the row or column
// register restarts loading at cell (0,0).
module dtw_cost_and_path
  import dtw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // [15:0] distance, [22:16] path_index, [23] zero
  input  wire logic [23:0]       s_tdata,
  // [0] action
  input  wire logic              s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // [23:0] total_cost, [30:24] path_length, [36:31] path_row, [42:37] path_col,
  // [43] index_valid, [47:44] zero
  output logic [47:0]            m_tdata,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  cfg_t    cfg;
  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] cols_in_use;
  logic    cfg_wr;

  assign in_item = '{action: s_tuser, distance: s_tdata[15:0], path_index: s_tdata[22:16]};
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= SIZE_W'(MAX_ROWS);
      cols_in_use <= SIZE_W'(MAX_COLS);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..max.
  always_comb begin
    cfg.restart = cfg_wr && (cfg_index == REG_ROWS || cfg_index == REG_COLS);
    if (rows_in_use == '0) cfg.nr = SIZE_W'(1);
    else if (rows_in_use > SIZE_W'(MAX_ROWS)) cfg.nr = SIZE_W'(MAX_ROWS);
    else cfg.nr = rows_in_use;
    if (cols_in_use == '0) cfg.nc = SIZE_W'(1);
    else if (cols_in_use > SIZE_W'(MAX_COLS)) cfg.nc = SIZE_W'(MAX_COLS);
    else cfg.nc = cols_in_use;
  end

  dtw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  dtw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'b0, res.index_valid, res.path_col, res.path_row,
                  res.path_length, res.total_cost};
    end
  end

endmodule
`default_nettype wire
